@@ src/graph_wave_topological_sort_macros.svh @@
// Assertion macros shared by the checker.
`ifndef GRAPH_WAVE_TOPOLOGICAL_SORT_MACROS_SVH
`define GRAPH_WAVE_TOPOLOGICAL_SORT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define GWTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define GWTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ src/gwts_pkg.sv @@
package gwts_pkg;

  // Default table sizes.
  localparam int MAX_NODES_DEF = 64;
  localparam int MAX_EDGES_DEF = 256;

  // Operation codes.
  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_REMOVE  = 3'd1,
    OP_SETPRI  = 3'd2,
    OP_CONNECT = 3'd3,
    OP_DISCONN = 3'd4,
    OP_RUN     = 3'd5,
    OP_CLEAR   = 3'd6
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_BAD   = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_EMPTY = 2'd3
  } stat_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE, S_EXEC, S_REM_RD, S_REM_CHK, S_ZERO, S_C_RD, S_C_CHK, S_C_UPD,
    S_S_RD, S_S_CHK, S_W_START, S_P_RD, S_P_CMP, S_EMIT, S_E_RD, S_E_CHK,
    S_E_UPD, S_FINISH
  } state_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic [5:0]         node_id;
    logic [5:0]         target_node;
    logic signed [31:0] priority_req;
    logic [7:0]         edge_id;
  } in_t;

  typedef struct packed {
    logic [5:0] node_id_res;
    logic [7:0] edge_id_res;
    logic [5:0] wave_index;
    logic [1:0] status;
    logic       last;
  } res_t;

endpackage

@@ src/gwts_cmp.sv @@
module gwts_cmp #(
  parameter int NW = 6
) (
  input  logic signed [31:0] a_prio,
  input  logic [NW-1:0]      a_id,
  input  logic signed [31:0] b_prio,
  input  logic [NW-1:0]      b_id,
  output logic               a_first
);

  // Higher priority wins; on a tie the lower node id goes first.
  always_comb begin
    a_first = (a_prio > b_prio) || ((a_prio == b_prio) && (a_id < b_id));
  end

endmodule

@@ src/gwts_outreg.sv @@
module gwts_outreg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  gwts_pkg::res_t  push_data,
  output logic            can_push,
  output logic            out_valid,
  input  logic            out_stall,
  output gwts_pkg::res_t  out_data
);
  import gwts_pkg::*;

  logic valid_r;
  res_t data_r;

  // A new item may enter when the register is empty or is being taken.
  assign can_push  = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push && can_push) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (push && can_push) begin
      data_r <= push_data;
    end
  end

endmodule

@@ src/graph_wave_topological_sort.sv @@
// Graph editor with a level-by-level topological sort.
// Input channel (in_valid, in_stall, in_data): one operation per item. The
// block raises in_stall from the cycle after it accepts an item until the
// final result of that item has entered the output register.
// Output channel (out_valid, out_stall, out_data): one result per edit; a
// run gives one result per emitted node, last set on the final one.
// Add, set priority, connect, disconnect and clear are done in the EXEC
// state, which pushes their result into the output register once it has
// room; remove first walks every allocated edge through the single edge
// table read port. A run clears all MAX_NODES in-degree entries, counts
// in-degrees over the allocated edges and seeds the first wave; then per
// wave it picks each emitted node by a priority scan over the allocated
// nodes through the shared comparator, ends with one closing scan and
// walks the edges to release successors. A new item is taken once the
// previous one is done.
// Reset (rst_n low, synchronous) empties both tables and the output register.
// When the receiver stalls, the output register holds its item and the
// sequencer waits before pushing the next one; no result is lost.
module graph_wave_topological_sort #(
  parameter int MAX_NODES = gwts_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES = gwts_pkg::MAX_EDGES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  gwts_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output gwts_pkg::res_t out_data
);
  import gwts_pkg::*;

  localparam int NW  = $clog2(MAX_NODES);
  localparam int NCW = $clog2(MAX_NODES + 1);
  localparam int EW  = $clog2(MAX_EDGES);
  localparam int ECW = $clog2(MAX_EDGES + 1);

  state_t state_r, state_nxt;

  // Latched operation.
  logic [2:0]         op_r, op_nxt;
  logic [5:0]         nid_r, nid_nxt;
  logic [5:0]         tgt_r, tgt_nxt;
  logic signed [31:0] prio_r, prio_nxt;
  logic [7:0]         eid_r, eid_nxt;

  // Table bookkeeping.
  logic [MAX_NODES-1:0] node_live_r, node_live_nxt;
  logic [MAX_EDGES-1:0] edge_live_r, edge_live_nxt;
  logic [NCW-1:0]       nodes_alloc_r, nodes_alloc_nxt;
  logic [ECW-1:0]       edges_alloc_r, edges_alloc_nxt;

  // Run scratch.
  logic [NCW-1:0]       ni_r, ni_nxt;
  logic [ECW-1:0]       e_r, e_nxt;
  logic [MAX_NODES-1:0] cur_mask_r, cur_mask_nxt;
  logic [MAX_NODES-1:0] nxt_mask_r, nxt_mask_nxt;
  logic [MAX_NODES-1:0] sel_mask_r, sel_mask_nxt;
  logic [NW-1:0]        best_id_r, best_id_nxt;
  logic signed [31:0]   best_prio_r, best_prio_nxt;
  logic                 found_r, found_nxt;
  res_t                 hold_r, hold_nxt;
  logic                 hold_v_r, hold_v_nxt;
  logic [NCW-1:0]       wave_r, wave_nxt;

  // Memories.
  logic signed [31:0] prio_mem [MAX_NODES];
  logic signed [31:0] prio_q_r;
  logic               prio_we, prio_re;
  logic [NW-1:0]      prio_waddr, prio_raddr;
  logic signed [31:0] prio_wdata;

  logic [2*NW-1:0] edge_mem [MAX_EDGES];
  logic [2*NW-1:0] edge_q_r;
  logic            edge_we, edge_re;
  logic [EW-1:0]   edge_waddr, edge_raddr;
  logic [2*NW-1:0] edge_wdata;

  logic [ECW-1:0] indeg_mem [MAX_NODES];
  logic [ECW-1:0] indeg_q_r;
  logic           indeg_we, indeg_re;
  logic [NW-1:0]  indeg_waddr, indeg_raddr;
  logic [ECW-1:0] indeg_wdata;

  // Output side.
  logic push, can_push;
  res_t push_data;

  logic          nid_ok, tgt_ok, eid_ok, a_first;
  logic [NW-1:0] edge_src, edge_dst, ni_idx;
  logic [EW-1:0] e_idx;

  assign ni_idx   = ni_r[NW-1:0];
  assign e_idx    = e_r[EW-1:0];
  assign edge_src = edge_q_r[2*NW-1:NW];
  assign edge_dst = edge_q_r[NW-1:0];
  assign nid_ok   = (32'(nid_r) < 32'(nodes_alloc_r)) && node_live_r[NW'(nid_r)];
  assign tgt_ok   = (32'(tgt_r) < 32'(nodes_alloc_r)) && node_live_r[NW'(tgt_r)];
  assign eid_ok   = (32'(eid_r) < 32'(edges_alloc_r)) && edge_live_r[EW'(eid_r)];
  assign in_stall = (state_r != S_IDLE);

  // Shared priority comparator used by the selection scan.
  gwts_cmp #(.NW(NW)) u_cmp (
    .a_prio  (prio_q_r),
    .a_id    (ni_idx),
    .b_prio  (best_prio_r),
    .b_id    (best_id_r),
    .a_first (a_first)
  );

  gwts_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Sequencer: next state, bookkeeping and memory controls.
  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    nid_nxt         = nid_r;
    tgt_nxt         = tgt_r;
    prio_nxt        = prio_r;
    eid_nxt         = eid_r;
    node_live_nxt   = node_live_r;
    edge_live_nxt   = edge_live_r;
    nodes_alloc_nxt = nodes_alloc_r;
    edges_alloc_nxt = edges_alloc_r;
    ni_nxt          = ni_r;
    e_nxt           = e_r;
    cur_mask_nxt    = cur_mask_r;
    nxt_mask_nxt    = nxt_mask_r;
    sel_mask_nxt    = sel_mask_r;
    best_id_nxt     = best_id_r;
    best_prio_nxt   = best_prio_r;
    found_nxt       = found_r;
    hold_nxt        = hold_r;
    hold_v_nxt      = hold_v_r;
    wave_nxt        = wave_r;
    prio_we         = 1'b0;
    prio_waddr      = NW'(nid_r);
    prio_wdata      = prio_r;
    prio_re         = 1'b0;
    prio_raddr      = ni_idx;
    edge_we         = 1'b0;
    edge_waddr      = edges_alloc_r[EW-1:0];
    edge_wdata      = {NW'(nid_r), NW'(tgt_r)};
    edge_re         = 1'b0;
    edge_raddr      = e_idx;
    indeg_we        = 1'b0;
    indeg_waddr     = edge_dst;
    indeg_wdata     = '0;
    indeg_re        = 1'b0;
    indeg_raddr     = edge_dst;
    push            = 1'b0;
    push_data       = '0;
    push_data.last  = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt   = in_data.operation;
          nid_nxt  = in_data.node_id;
          tgt_nxt  = in_data.target_node;
          prio_nxt = in_data.priority_req;
          eid_nxt  = in_data.edge_id;
          if (in_data.operation == OP_RUN) begin
            ni_nxt       = '0;
            cur_mask_nxt = '0;
            nxt_mask_nxt = '0;
            hold_v_nxt   = 1'b0;
            wave_nxt     = '0;
            state_nxt    = S_ZERO;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end

      // Single-result edits.
      S_EXEC: begin
        if (op_r == OP_REMOVE && nid_ok) begin
          e_nxt     = '0;
          state_nxt = S_REM_RD;
        end else if (can_push) begin
          push      = 1'b1;
          state_nxt = S_IDLE;
          case (op_r)
            OP_ADD: begin
              if (nodes_alloc_r == NCW'(MAX_NODES)) begin
                push_data.status = STAT_FULL;
              end else begin
                node_live_nxt[nodes_alloc_r[NW-1:0]] = 1'b1;
                prio_we     = 1'b1;
                prio_waddr  = nodes_alloc_r[NW-1:0];
                prio_wdata  = '0;
                push_data.node_id_res = 6'(nodes_alloc_r);
                nodes_alloc_nxt = NCW'(nodes_alloc_r + 1'b1);
              end
            end
            OP_SETPRI: begin
              if (nid_ok) begin
                prio_we = 1'b1;
              end else begin
                push_data.status = STAT_BAD;
              end
            end
            OP_CONNECT: begin
              if (!nid_ok || !tgt_ok) begin
                push_data.status = STAT_BAD;
              end else if (edges_alloc_r == ECW'(MAX_EDGES)) begin
                push_data.status = STAT_FULL;
              end else begin
                edge_we = 1'b1;
                edge_live_nxt[edges_alloc_r[EW-1:0]] = 1'b1;
                push_data.edge_id_res = 8'(edges_alloc_r);
                edges_alloc_nxt = ECW'(edges_alloc_r + 1'b1);
              end
            end
            OP_DISCONN: begin
              if (eid_ok) begin
                edge_live_nxt[EW'(eid_r)] = 1'b0;
              end else begin
                push_data.status = STAT_BAD;
              end
            end
            OP_CLEAR: begin
              node_live_nxt   = '0;
              edge_live_nxt   = '0;
              nodes_alloc_nxt = '0;
              edges_alloc_nxt = '0;
            end
            default: begin
              push_data.status = STAT_BAD;
            end
          endcase
        end
      end

      // Remove: walk all allocated edges, dropping those that touch the node.
      S_REM_RD: begin
        if (e_r == edges_alloc_r) begin
          if (can_push) begin
            push = 1'b1;
            node_live_nxt[NW'(nid_r)] = 1'b0;
            state_nxt = S_IDLE;
          end
        end else begin
          edge_re   = 1'b1;
          state_nxt = S_REM_CHK;
        end
      end

      S_REM_CHK: begin
        if (edge_live_r[e_idx] && (edge_src == NW'(nid_r) || edge_dst == NW'(nid_r))) begin
          edge_live_nxt[e_idx] = 1'b0;
        end
        e_nxt     = ECW'(e_r + 1'b1);
        state_nxt = S_REM_RD;
      end

      // Run: clear the in-degree table.
      S_ZERO: begin
        indeg_we    = 1'b1;
        indeg_waddr = ni_idx;
        indeg_wdata = '0;
        if (ni_r == NCW'(MAX_NODES - 1)) begin
          e_nxt     = '0;
          state_nxt = S_C_RD;
        end else begin
          ni_nxt = NCW'(ni_r + 1'b1);
        end
      end

      // Count in-degrees over live edges.
      S_C_RD: begin
        if (e_r == edges_alloc_r) begin
          ni_nxt    = '0;
          state_nxt = S_S_RD;
        end else begin
          edge_re   = 1'b1;
          state_nxt = S_C_CHK;
        end
      end

      S_C_CHK: begin
        if (edge_live_r[e_idx]) begin
          indeg_re  = 1'b1;
          state_nxt = S_C_UPD;
        end else begin
          e_nxt     = ECW'(e_r + 1'b1);
          state_nxt = S_C_RD;
        end
      end

      S_C_UPD: begin
        indeg_we    = 1'b1;
        indeg_wdata = ECW'(indeg_q_r + 1'b1);
        e_nxt       = ECW'(e_r + 1'b1);
        state_nxt   = S_C_RD;
      end

      // Seed the first wave with live nodes of in-degree zero.
      S_S_RD: begin
        if (ni_r == nodes_alloc_r) begin
          state_nxt = S_W_START;
        end else begin
          indeg_re    = 1'b1;
          indeg_raddr = ni_idx;
          state_nxt   = S_S_CHK;
        end
      end

      S_S_CHK: begin
        if (node_live_r[ni_idx] && indeg_q_r == '0) begin
          cur_mask_nxt[ni_idx] = 1'b1;
        end
        ni_nxt    = NCW'(ni_r + 1'b1);
        state_nxt = S_S_RD;
      end

      S_W_START: begin
        if (cur_mask_r == '0) begin
          state_nxt = S_FINISH;
        end else begin
          sel_mask_nxt = cur_mask_r;
          ni_nxt       = '0;
          found_nxt    = 1'b0;
          state_nxt    = S_P_RD;
        end
      end

      // Pick the best remaining node of the wave.
      S_P_RD: begin
        if (ni_r == nodes_alloc_r) begin
          if (found_r) begin
            state_nxt = S_EMIT;
          end else begin
            e_nxt     = '0;
            state_nxt = S_E_RD;
          end
        end else if (sel_mask_r[ni_idx]) begin
          prio_re   = 1'b1;
          state_nxt = S_P_CMP;
        end else begin
          ni_nxt = NCW'(ni_r + 1'b1);
        end
      end

      S_P_CMP: begin
        if (!found_r || a_first) begin
          best_prio_nxt = prio_q_r;
          best_id_nxt   = ni_idx;
          found_nxt     = 1'b1;
        end
        ni_nxt    = NCW'(ni_r + 1'b1);
        state_nxt = S_P_RD;
      end

      // The previous node goes out; the new one waits until its last flag is known.
      S_EMIT: begin
        if (!hold_v_r || can_push) begin
          if (hold_v_r) begin
            push      = 1'b1;
            push_data = hold_r;
          end
          hold_nxt             = '0;
          hold_nxt.node_id_res = 6'(best_id_r);
          hold_nxt.wave_index  = 6'(wave_r);
          hold_nxt.status      = STAT_OK;
          hold_v_nxt           = 1'b1;
          sel_mask_nxt[best_id_r] = 1'b0;
          ni_nxt    = '0;
          found_nxt = 1'b0;
          state_nxt = S_P_RD;
        end
      end

      // Release successors of the wave just emitted.
      S_E_RD: begin
        if (e_r == edges_alloc_r) begin
          cur_mask_nxt = nxt_mask_r;
          nxt_mask_nxt = '0;
          wave_nxt     = NCW'(wave_r + 1'b1);
          state_nxt    = S_W_START;
        end else begin
          edge_re   = 1'b1;
          state_nxt = S_E_CHK;
        end
      end

      S_E_CHK: begin
        if (edge_live_r[e_idx] && cur_mask_r[edge_src]) begin
          indeg_re  = 1'b1;
          state_nxt = S_E_UPD;
        end else begin
          e_nxt     = ECW'(e_r + 1'b1);
          state_nxt = S_E_RD;
        end
      end

      S_E_UPD: begin
        if (indeg_q_r != '0) begin
          indeg_we    = 1'b1;
          indeg_wdata = ECW'(indeg_q_r - 1'b1);
          if (indeg_q_r == ECW'(1)) begin
            nxt_mask_nxt[edge_dst] = 1'b1;
          end
        end
        e_nxt     = ECW'(e_r + 1'b1);
        state_nxt = S_E_RD;
      end

      // Final result of a run.
      S_FINISH: begin
        if (can_push) begin
          push = 1'b1;
          if (hold_v_r) begin
            push_data      = hold_r;
            push_data.last = 1'b1;
          end else begin
            push_data.status = STAT_EMPTY;
          end
          hold_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      node_live_r   <= '0;
      edge_live_r   <= '0;
      nodes_alloc_r <= '0;
      edges_alloc_r <= '0;
      ni_r          <= '0;
      e_r           <= '0;
      cur_mask_r    <= '0;
      nxt_mask_r    <= '0;
      sel_mask_r    <= '0;
      found_r       <= 1'b0;
      hold_v_r      <= 1'b0;
      wave_r        <= '0;
    end else begin
      state_r       <= state_nxt;
      node_live_r   <= node_live_nxt;
      edge_live_r   <= edge_live_nxt;
      nodes_alloc_r <= nodes_alloc_nxt;
      edges_alloc_r <= edges_alloc_nxt;
      ni_r          <= ni_nxt;
      e_r           <= e_nxt;
      cur_mask_r    <= cur_mask_nxt;
      nxt_mask_r    <= nxt_mask_nxt;
      sel_mask_r    <= sel_mask_nxt;
      found_r       <= found_nxt;
      hold_v_r      <= hold_v_nxt;
      wave_r        <= wave_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    nid_r       <= nid_nxt;
    tgt_r       <= tgt_nxt;
    prio_r      <= prio_nxt;
    eid_r       <= eid_nxt;
    best_id_r   <= best_id_nxt;
    best_prio_r <= best_prio_nxt;
    hold_r      <= hold_nxt;
  end

  // Priority memory.
  always_ff @(posedge clk) begin
    if (prio_we) begin
      prio_mem[prio_waddr] <= prio_wdata;
    end
    if (prio_re) begin
      prio_q_r <= prio_mem[prio_raddr];
    end
  end

  // Edge endpoint memory.
  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[edge_waddr] <= edge_wdata;
    end
    if (edge_re) begin
      edge_q_r <= edge_mem[edge_raddr];
    end
  end

  // In-degree memory.
  always_ff @(posedge clk) begin
    if (indeg_we) begin
      indeg_mem[indeg_waddr] <= indeg_wdata;
    end
    if (indeg_re) begin
      indeg_q_r <= indeg_mem[indeg_raddr];
    end
  end

endmodule

@@ src/gwts_checker.sv @@
`include "graph_wave_topological_sort_macros.svh"

module gwts_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input gwts_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_stall,
  input gwts_pkg::res_t out_data
);
  import gwts_pkg::*;

  // A stalled result item stays offered and unchanged.
  `GWTS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `GWTS_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_data))

  // A stalled input item keeps its payload.
  `GWTS_ASSERT_NEXT(a_in_stable, clk, rst_n, in_valid && in_stall, $stable(in_data))

  // Once an item is taken the block is busy with it.
  `GWTS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

  // While a run still owes results no new item is taken.
  `GWTS_ASSERT_NOW(a_busy_mid_run, clk, rst_n, out_valid && !out_stall && !out_data.last,
    in_stall)

endmodule

bind graph_wave_topological_sort gwts_checker u_gwts_checker (.*);

@@ bench/graph_wave_topological_sort_tb.sv @@
module graph_wave_topological_sort_tb;
  import gwts_pkg::*;

  localparam int NODE_CAP = MAX_NODES_DEF;
  localparam int EDGE_CAP = MAX_EDGES_DEF;
  localparam int CYCLE_LIMIT = 100000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  res_t out_data;

  graph_wave_topological_sort dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the graph tables.
  bit          shadow_node_live [NODE_CAP];
  logic [31:0] shadow_priority [NODE_CAP];
  int          shadow_nodes;
  bit          shadow_edge_live [EDGE_CAP];
  int          shadow_src [EDGE_CAP];
  int          shadow_dst [EDGE_CAP];
  int          shadow_edges;

  res_t expected_results[$];
  int   fail_count = 0;
  int   cycle_count = 0;
  int   quiet_left = 0;
  bit   stimulus_done = 1'b0;

  // Idle length: mostly short, sometimes long, with quiet stretches of none.
  function automatic int pick_gap();
    int r;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) quiet_left = $urandom_range(20, 60);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit node_valid(int id);
    return id < shadow_nodes && shadow_node_live[id];
  endfunction

  function automatic bit ranks_first(int a, int b);
    if ($signed(shadow_priority[a]) != $signed(shadow_priority[b]))
      return $signed(shadow_priority[a]) > $signed(shadow_priority[b]);
    return a < b;
  endfunction

  task automatic push_result(int nid, int eid, int wave, stat_t st, bit fin);
    res_t r;
    r.node_id_res = nid[5:0];
    r.edge_id_res = eid[7:0];
    r.wave_index  = wave[5:0];
    r.status      = st;
    r.last        = fin;
    expected_results = {expected_results, r};
  endtask

  // Level-by-level sort over the shadow graph.
  task automatic predict_waves();
    int indeg [NODE_CAP];
    int cur[$];
    int nxt[$];
    int wave;
    int emitted;
    int v, j, d;
    wave = 0;
    emitted = 0;
    foreach (indeg[i]) indeg[i] = 0;
    for (int e = 0; e < shadow_edges; e++)
      if (shadow_edge_live[e]) indeg[shadow_dst[e]]++;
    for (int i = 0; i < shadow_nodes; i++)
      if (shadow_node_live[i] && indeg[i] == 0) cur = {cur, i};
    while (cur.size() > 0) begin
      for (int i = 1; i < cur.size(); i++) begin
        v = cur[i];
        j = i;
        while (j > 0 && ranks_first(v, cur[j-1])) begin
          cur[j] = cur[j-1];
          j--;
        end
        cur[j] = v;
      end
      foreach (cur[i]) begin
        push_result(cur[i], 0, wave, STAT_OK, 1'b0);
        emitted++;
      end
      nxt.delete();
      foreach (cur[i])
        for (int e = 0; e < shadow_edges; e++)
          if (shadow_edge_live[e] && shadow_src[e] == cur[i]) begin
            d = shadow_dst[e];
            if (indeg[d] > 0) begin
              indeg[d]--;
              if (indeg[d] == 0) nxt = {nxt, d};
            end
          end
      cur = nxt;
      wave++;
    end
    if (emitted == 0) push_result(0, 0, 0, STAT_EMPTY, 1'b1);
    else expected_results[$].last = 1'b1;
  endtask

  // Applies one accepted item to the shadow graph and queues its results.
  task automatic predict_item(in_t it);
    int nid, tgt, eid;
    nid = it.node_id;
    tgt = it.target_node;
    eid = it.edge_id;
    case (it.operation)
      OP_ADD: begin
        if (shadow_nodes >= NODE_CAP) push_result(0, 0, 0, STAT_FULL, 1'b1);
        else begin
          shadow_node_live[shadow_nodes] = 1'b1;
          shadow_priority[shadow_nodes] = '0;
          push_result(shadow_nodes, 0, 0, STAT_OK, 1'b1);
          shadow_nodes++;
        end
      end
      OP_REMOVE: begin
        if (!node_valid(nid)) push_result(0, 0, 0, STAT_BAD, 1'b1);
        else begin
          for (int e = 0; e < shadow_edges; e++)
            if (shadow_src[e] == nid || shadow_dst[e] == nid) shadow_edge_live[e] = 1'b0;
          shadow_node_live[nid] = 1'b0;
          push_result(0, 0, 0, STAT_OK, 1'b1);
        end
      end
      OP_SETPRI: begin
        if (!node_valid(nid)) push_result(0, 0, 0, STAT_BAD, 1'b1);
        else begin
          shadow_priority[nid] = it.priority_req;
          push_result(0, 0, 0, STAT_OK, 1'b1);
        end
      end
      OP_CONNECT: begin
        if (!node_valid(nid) || !node_valid(tgt)) push_result(0, 0, 0, STAT_BAD, 1'b1);
        else if (shadow_edges >= EDGE_CAP) push_result(0, 0, 0, STAT_FULL, 1'b1);
        else begin
          shadow_edge_live[shadow_edges] = 1'b1;
          shadow_src[shadow_edges] = nid;
          shadow_dst[shadow_edges] = tgt;
          push_result(0, shadow_edges, 0, STAT_OK, 1'b1);
          shadow_edges++;
        end
      end
      OP_DISCONN: begin
        if (eid >= shadow_edges || !shadow_edge_live[eid])
          push_result(0, 0, 0, STAT_BAD, 1'b1);
        else begin
          shadow_edge_live[eid] = 1'b0;
          push_result(0, 0, 0, STAT_OK, 1'b1);
        end
      end
      OP_RUN: predict_waves();
      OP_CLEAR: begin
        foreach (shadow_node_live[i]) shadow_node_live[i] = 1'b0;
        foreach (shadow_edge_live[i]) shadow_edge_live[i] = 1'b0;
        shadow_nodes = 0;
        shadow_edges = 0;
        push_result(0, 0, 0, STAT_OK, 1'b1);
      end
      default: push_result(0, 0, 0, STAT_BAD, 1'b1);
    endcase
  endtask

  // Sends one item after a random gap and waits for it to be taken.
  task automatic send_item(logic [2:0] op, int nid, int tgt, logic [31:0] prio, int eid);
    int gap;
    in_t it;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    it.operation    = op;
    it.node_id      = nid[5:0];
    it.target_node  = tgt[5:0];
    it.priority_req = prio;
    it.edge_id      = eid[7:0];
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    predict_item(it);
  endtask

  // Withdraws the sender and waits until every expected result has come.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Every operation, bad ids, self loop, cycle, extremes of priority.
  task automatic test_directed_edits();
    send_item(OP_RUN, 0, 0, 0, 0);
    send_item(OP_REMOVE, 0, 0, 0, 0);
    send_item(OP_ADD, 63, 63, 32'hFFFF_FFFF, 255);
    send_item(OP_ADD, 0, 0, 0, 0);
    send_item(OP_ADD, 0, 0, 0, 0);
    send_item(OP_ADD, 0, 0, 0, 0);
    send_item(OP_SETPRI, 1, 0, 32'h7FFF_FFFF, 0);
    send_item(OP_SETPRI, 2, 0, 32'h8000_0000, 0);
    send_item(OP_SETPRI, 63, 0, 32'h1234_5678, 0);
    send_item(OP_CONNECT, 0, 3, 0, 0);
    send_item(OP_CONNECT, 3, 3, 0, 0);
    send_item(OP_CONNECT, 0, 40, 0, 0);
    send_item(OP_RUN, 0, 0, 0, 0);
    send_item(OP_DISCONN, 0, 0, 0, 1);
    send_item(OP_DISCONN, 0, 0, 0, 255);
    send_item(OP_DISCONN, 0, 0, 0, 1);
    send_item(3'd7, 21, 42, 32'h5555_AAAA, 170);
    send_item(OP_CONNECT, 1, 2, 0, 0);
    send_item(OP_CONNECT, 2, 1, 0, 0);
    send_item(OP_RUN, 0, 0, 0, 0);
    send_item(OP_REMOVE, 1, 0, 0, 0);
    send_item(OP_SETPRI, 1, 0, 32'h0000_0001, 0);
    send_item(OP_RUN, 0, 0, 0, 0);
    send_item(OP_CLEAR, 0, 0, 0, 0);
    send_item(OP_RUN, 0, 0, 0, 0);
  endtask

  // Fills the node table, overflows it, and sorts a long chain.
  task automatic test_node_table_full();
    send_item(OP_CLEAR, 0, 0, 0, 0);
    for (int i = 0; i < NODE_CAP + 1; i++) send_item(OP_ADD, 0, 0, 0, 0);
    for (int i = 0; i < NODE_CAP - 1; i++) send_item(OP_CONNECT, i + 1, i, 0, 0);
    send_item(OP_SETPRI, 63, 0, $urandom, 0);
    send_item(OP_RUN, 0, 0, 0, 0);
    send_item(OP_REMOVE, 63, 0, 0, 0);
    send_item(OP_RUN, 0, 0, 0, 0);
  endtask

  // Fills the rest of the edge table on the full node table and overflows it.
  task automatic test_edge_table_full();
    int a, b;
    while (shadow_edges < EDGE_CAP) begin
      a = $urandom_range(1, NODE_CAP - 2);
      b = $urandom_range(0, a - 1);
      send_item(OP_CONNECT, a, b, 0, 0);
    end
    send_item(OP_CONNECT, 2, 1, 0, 0);
    // Once, hold the sender back until every result is in.
    wait_drained();
    for (int i = 0; i < 4; i++)
      send_item(OP_SETPRI, $urandom_range(0, NODE_CAP - 2), 0, $urandom, 0);
    send_item(OP_RUN, 0, 0, 0, 0);
    send_item(OP_DISCONN, 0, 0, 0, 255);
    send_item(OP_REMOVE, 1, 0, 0, 0);
    send_item(OP_CONNECT, 0, 3, 0, 0);
    send_item(OP_RUN, 0, 0, 0, 0);
  endtask

  // Receiver: stall for random stretches.
  initial begin
    int hold;
    forever begin
      hold = pick_gap();
      if (hold > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (hold - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
  end

  // Compares each result taken with the oldest expected one.
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result %p", out_data);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.node_id_res !== want.node_id_res) begin
          $error("node_id_res expected %0d actual %0d", want.node_id_res, out_data.node_id_res);
          fail_count++;
        end
        if (out_data.edge_id_res !== want.edge_id_res) begin
          $error("edge_id_res expected %0d actual %0d", want.edge_id_res, out_data.edge_id_res);
          fail_count++;
        end
        if (out_data.wave_index !== want.wave_index) begin
          $error("wave_index expected %0d actual %0d", want.wave_index, out_data.wave_index);
          fail_count++;
        end
        if (out_data.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, out_data.status);
          fail_count++;
        end
        if (out_data.last !== want.last) begin
          $error("last expected %0d actual %0d", want.last, out_data.last);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    shadow_nodes = 0;
    shadow_edges = 0;
    foreach (shadow_node_live[i]) shadow_node_live[i] = 1'b0;
    foreach (shadow_edge_live[i]) shadow_edge_live[i] = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    test_directed_edits();
    test_node_table_full();
    test_edge_table_full();
    wait_drained();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/gwts_pkg.sv
src/gwts_cmp.sv
src/gwts_outreg.sv
src/graph_wave_topological_sort.sv
src/gwts_checker.sv
bench/graph_wave_topological_sort_tb.sv
